[sv/dual_pol_stokes_products_assert.svh]
// ----------------------------------------------------------------------------
// dual_pol_stokes_products_assert
// assertion macros shared by the polarization product block
// ----------------------------------------------------------------------------
`ifndef DUAL_POL_STOKES_PRODUCTS_ASSERT_SVH
`define DUAL_POL_STOKES_PRODUCTS_ASSERT_SVH

// property that must hold at every clock edge out of reset
`define DPSP_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// condition in one cycle implies a result in the next one
`define DPSP_ASSERT_NEXT(label, clk, rst_n, cond, res, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (res)) \
    else $error(msg);

`endif

[sv/dpsp_pkg.sv]
// ----------------------------------------------------------------------------
// dpsp_pkg
// field widths and types of the dual polarization product block
// ----------------------------------------------------------------------------
`default_nettype none

package dpsp_pkg;

  localparam int unsigned SampleW = 16;
  localparam int unsigned BeamW   = 10;
  localparam int unsigned CountW  = 11;
  localparam int unsigned ProdW   = 2 * SampleW;
  localparam int unsigned PowerW  = 32;
  localparam int unsigned CrossW  = 33;

  localparam int unsigned InDataW    = 2 * SampleW;
  localparam int unsigned OutFieldsW = BeamW + 2 * PowerW + 2 * CrossW;
  localparam int unsigned OutDataW   = ((OutFieldsW + 7) / 8) * 8;

  typedef logic signed [SampleW-1:0] sample_t;
  typedef logic signed [ProdW-1:0]   prod_t;
  typedef logic signed [CrossW-1:0]  cross_t;

  typedef struct packed {
    sample_t im;
    sample_t re;
  } x_entry_t;

endpackage

`default_nettype wire

[sv/dual_pol_stokes_products.sv]
// a Y item's result is formed with one register per stage (read, multiply, sum)
// throughput: one item per cycle, Y only while not stalled; X items give no result
// the X store is one synchronous ram with registered read, written by X and read by Y
// reset clears position, phase, beam count (to 1) and the pipeline valids;
// the X store is not cleared, there is no clearing pass
`default_nettype none

// ----------------------------------------------------------------------------
// dual_pol_stokes_products
// stores X samples by beam, then forms |X|^2, |Y|^2 and X*conj(Y) for each Y
// ----------------------------------------------------------------------------
module dual_pol_stokes_products #(
  parameter int unsigned MAX_BEAMS = 1024
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  // configuration: beam_count
  input  wire logic                          cfg_valid_i,
  output logic                               cfg_ready_o,
  input  wire logic [dpsp_pkg::CountW-1:0]   cfg_data_i,
  // input items
  input  wire logic                          s_axis_tvalid,
  output logic                               s_axis_tready,
  // sample_real, sample_imag
  input  wire logic [dpsp_pkg::InDataW-1:0]  s_axis_tdata,
  // result items
  output logic                               m_axis_tvalid,
  input  wire logic                          m_axis_tready,
  // beam, power_x, power_y, cross_real, cross_imag, zero pad
  output logic [dpsp_pkg::OutDataW-1:0]      m_axis_tdata
);
  import dpsp_pkg::*;

  `include "dual_pol_stokes_products_assert.svh"

  localparam int unsigned PosW = (MAX_BEAMS > 1) ? $clog2(MAX_BEAMS) : 1;
  localparam int unsigned CntW = (CountW > PosW + 1) ? CountW : PosW + 1;
  localparam int unsigned PadW = OutDataW - OutFieldsW;

  // control state
  logic [CountW-1:0] beam_count_q;
  logic [PosW-1:0]   pos_q, pos_d;
  logic              phase_q, phase_d;   // 1: expecting polarization Y

  logic [CntW-1:0] active_cnt;
  logic [CntW-1:0] pos_inc;
  logic            wrap;

  logic cfg_acc, s_acc, x_acc, y_acc;
  logic ready1, ready2, ready3;

  // stage 1: ram read data and Y sample
  logic        v1_q;
  x_entry_t    x1_q;
  sample_t     yr1_q, yi1_q;
  logic [BeamW-1:0] beam1_q;

  // stage 2: products
  logic        v2_q;
  logic [BeamW-1:0] beam2_q;
  prod_t       p_xrxr_q, p_xixi_q, p_yryr_q, p_yiyi_q;
  prod_t       p_xryr_q, p_xiyi_q, p_xiyr_q, p_xryi_q;

  // stage 3: output register
  logic        v3_q;
  logic [BeamW-1:0]  beam3_q;
  logic [PowerW-1:0] pwr_x_q, pwr_y_q;
  cross_t      cr_re_q, cr_im_q;

  cross_t sum_xx, sum_yy;

  x_entry_t x_store [MAX_BEAMS];

  sample_t in_re, in_im;
  assign in_re = s_axis_tdata[SampleW-1:0];
  assign in_im = s_axis_tdata[2*SampleW-1:SampleW];

  always_comb begin
    if (beam_count_q == '0) begin
      active_cnt = CntW'(1);
    end else if (CntW'(beam_count_q) > CntW'(MAX_BEAMS)) begin
      active_cnt = CntW'(MAX_BEAMS);
    end else begin
      active_cnt = CntW'(beam_count_q);
    end
  end

  assign pos_inc = CntW'(pos_q) + CntW'(1);
  assign wrap    = (pos_inc >= active_cnt);

  assign ready3 = !v3_q || m_axis_tready;
  assign ready2 = !v2_q || ready3;
  assign ready1 = !v1_q || ready2;

  // X items only write the store, so they never wait on the pipeline
  assign s_axis_tready = !phase_q || ready1;
  assign cfg_ready_o   = 1'b1;

  assign cfg_acc = cfg_valid_i && cfg_ready_o;
  assign s_acc   = s_axis_tvalid && s_axis_tready;
  assign x_acc   = s_acc && !phase_q;
  assign y_acc   = s_acc && phase_q;

  always_comb begin
    pos_d   = pos_q;
    phase_d = phase_q;
    if (cfg_acc) begin
      pos_d   = '0;
      phase_d = 1'b0;
    end else if (s_acc) begin
      if (wrap) begin
        pos_d   = '0;
        phase_d = !phase_q;
      end else begin
        pos_d = pos_inc[PosW-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      beam_count_q <= CountW'(1);
      pos_q        <= '0;
      phase_q      <= 1'b0;
    end else begin
      if (cfg_acc) begin
        beam_count_q <= cfg_data_i;
      end
      pos_q   <= pos_d;
      phase_q <= phase_d;
    end
  end

  // a Y read of an entry comes in a later cycle than its X write,
  // and a cycle never holds both, so no forwarding is needed
  always_ff @(posedge clk_i) begin
    if (x_acc) begin
      x_store[pos_q] <= '{im: in_im, re: in_re};
    end
    if (y_acc) begin
      x1_q <= x_store[pos_q];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      if (ready1) begin
        v1_q <= y_acc;
      end
      if (ready2) begin
        v2_q <= v1_q;
      end
      if (ready3) begin
        v3_q <= v2_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (y_acc) begin
      yr1_q   <= in_re;
      yi1_q   <= in_im;
      beam1_q <= BeamW'(pos_q);
    end
    if (v1_q && ready2) begin
      beam2_q  <= beam1_q;
      p_xrxr_q <= x1_q.re * x1_q.re;
      p_xixi_q <= x1_q.im * x1_q.im;
      p_yryr_q <= yr1_q * yr1_q;
      p_yiyi_q <= yi1_q * yi1_q;
      p_xryr_q <= x1_q.re * yr1_q;
      p_xiyi_q <= x1_q.im * yi1_q;
      p_xiyr_q <= x1_q.im * yr1_q;
      p_xryi_q <= x1_q.re * yi1_q;
    end
    if (v2_q && ready3) begin
      beam3_q <= beam2_q;
      pwr_x_q <= sum_xx[PowerW-1:0];
      pwr_y_q <= sum_yy[PowerW-1:0];
      cr_re_q <= CrossW'(p_xryr_q) + CrossW'(p_xiyi_q);
      cr_im_q <= CrossW'(p_xiyr_q) - CrossW'(p_xryi_q);
    end
  end

  assign sum_xx = CrossW'(p_xrxr_q) + CrossW'(p_xixi_q);
  assign sum_yy = CrossW'(p_yryr_q) + CrossW'(p_yiyi_q);

  assign m_axis_tvalid = v3_q;
  assign m_axis_tdata  = {{PadW{1'b0}}, cr_im_q, cr_re_q, pwr_y_q, pwr_x_q, beam3_q};

  `DPSP_ASSERT(a_pos_in_range, clk_i, rst_ni, CntW'(pos_q) < active_cnt,
               "beam position reached the active beam count")
  `DPSP_ASSERT_NEXT(a_y_enters_pipe, clk_i, rst_ni, y_acc, v1_q,
                    "accepted Y item did not enter the product pipeline")
  `DPSP_ASSERT_NEXT(a_x_to_y_phase, clk_i, rst_ni, x_acc && wrap && !cfg_acc,
                    phase_q && (pos_q == '0), "last X item did not switch to polarization Y")

endmodule

`default_nettype wire
